// File: rtl/core/afrc_pkg.sv
// afrc_pkg: shared widths, register indexes, format codes and the
// command/status structs between controller and datapath.
// No dependencies.
package afrc_pkg;

    localparam int RAW_W      = 32;
    localparam int PCM_W      = 16;
    localparam int FMT_W      = 2;
    localparam int RATE_W     = 19;
    localparam int ACC_W      = 20;
    localparam int CHUNK_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int MAX_REPEAT_DEF = 16;

    // sample formats
    localparam logic [FMT_W-1:0] FMT_F32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_I16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_I32 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_I24 = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_STEREO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STEREO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_FRAMES  = 3'd5;

    // reset values
    localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_F32;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd48000;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd960;

    // substitute for a zero output rate
    localparam logic [RATE_W-1:0]  ORATE_ZERO_SUB = 19'd48000;

    typedef logic signed [PCM_W-1:0] t_pcm;

    typedef struct packed {
        logic cap;      // capture input word, start decode
        logic acc_add;  // add output rate into the accumulator
        logic emit;     // load one output frame
    } t_dp_cmd;

    typedef struct packed {
        logic rate_eq;  // effective rates equal
        logic rate_ge;  // accumulator >= input rate
        logic out_free; // output register can take a frame this cycle
    } t_dp_status;

endpackage

// File: rtl/core/afrc_if.sv
// afrc_if: valid/ready channel interfaces for input frames, output frames
// and configuration writes. Depends on afrc_pkg.
interface afrc_in_if;
    import afrc_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_left;
    logic [RAW_W-1:0] raw_right;
    logic             silent;
    modport source (output valid, raw_left, raw_right, silent, input ready);
    modport sink   (input valid, raw_left, raw_right, silent, output ready);
endinterface

interface afrc_out_if;
    import afrc_pkg::*;
    logic valid;
    logic ready;
    t_pcm pcm_left;
    t_pcm pcm_right;
    logic chunk_end;
    modport source (output valid, pcm_left, pcm_right, chunk_end, input ready);
    modport sink   (input valid, pcm_left, pcm_right, chunk_end, output ready);
endinterface

interface afrc_cfg_if;
    import afrc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/audio_format_rate_chunker.sv
// Audio format converter and zero-order-hold rate chunker, top level.
// Each input word passes, from its accept to the next accept, through the
// accept, the decode lanes (unpack, multiply by 32767, round and clamp), a
// step of the rate accumulator, then n output words (n from 0 to MAX_REPEAT),
// each through the single output register, and a final check that no further
// word is due. While the sink stalls the output register, the next word is
// held back. Input is
// accepted only between items; the last output word may still wait in the
// output register while the next input word is taken. Configuration writes
// are taken every cycle and must be made while the block is idle. Depends on
// afrc_pkg, afrc_if, afrc_ctrl and afrc_datapath.
module audio_format_rate_chunker #(
    parameter int MAX_REPEAT = afrc_pkg::MAX_REPEAT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afrc_in_if.sink     i_in,
    afrc_out_if.source  o_out,
    afrc_cfg_if.sink    i_cfg
);
    import afrc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    afrc_ctrl #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    afrc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw_left  (i_in.raw_left),
        .i_raw_right (i_in.raw_right),
        .i_silent    (i_in.silent),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/afrc_dec_lane.sv
// afrc_dec_lane: three-stage decoder of one raw channel word to int16
// (unpack, multiply by 32767, round-half-even and clamp). Depends on afrc_pkg.
module afrc_dec_lane (
    input  logic                          i_clk,
    input  logic [afrc_pkg::RAW_W-1:0]    i_raw,
    input  logic [afrc_pkg::FMT_W-1:0]    i_fmt,
    output afrc_pkg::t_pcm                o_sample
);
    import afrc_pkg::*;

    localparam int MAG_W  = 31;
    localparam int SH_W   = 8;
    localparam int PROD_W = 46;
    localparam int QMAG_W = PCM_W - 1;
    localparam logic [QMAG_W-1:0] SCALE = 15'd32767;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ZERO = 2'd1;
    localparam logic [1:0] SP_POS  = 2'd2;
    localparam logic [1:0] SP_NEG  = 2'd3;

    logic [7:0]        exp_f;
    logic [22:0]       frac_f;
    logic [15:0]       mag16;
    logic [23:0]       mag24;
    logic [31:0]       mag32;
    logic              n_neg;
    logic [MAG_W-1:0]  n_mag;
    logic [SH_W-1:0]   n_sh;
    logic [1:0]        n_sp;

    logic              r_neg1, r_neg2;
    logic [MAG_W-1:0]  r_mag;
    logic [SH_W-1:0]   r_sh1, r_sh2;
    logic [1:0]        r_sp1, r_sp2;
    logic [PROD_W-1:0] r_prod;
    t_pcm              r_sample;

    logic [PROD_W-1:0] q, q_rnd, guard_vec, low_mask;
    logic              guard, sticky, round_up;
    logic [QMAG_W-1:0] q_sat;
    t_pcm              n_sample;

    assign exp_f  = i_raw[30:23];
    assign frac_f = i_raw[22:0];

    // stage 1: sign, magnitude, shift and the saturating/zero cases
    always_comb begin
        n_neg = 1'b0;
        n_mag = '0;
        n_sh  = 8'd15;
        n_sp  = SP_NONE;
        mag16 = 16'd0 - i_raw[15:0];
        mag24 = 24'd0 - i_raw[31:8];
        mag32 = 32'd0 - i_raw;
        unique case (i_fmt)
            FMT_F32: begin
                n_neg = i_raw[31];
                if (exp_f == 8'hFF && frac_f != 23'd0) begin
                    n_sp = SP_ZERO;
                end else if (exp_f >= 8'd127) begin
                    n_sp = i_raw[31] ? SP_NEG : SP_POS;
                end else if (exp_f == 8'd0) begin
                    n_mag = MAG_W'(frac_f);
                    n_sh  = 8'd149;
                end else begin
                    n_mag = MAG_W'({1'b1, frac_f});
                    n_sh  = 8'd150 - exp_f;
                end
            end
            FMT_I16: begin
                n_neg = i_raw[15];
                n_sh  = 8'd15;
                n_mag = i_raw[15] ? MAG_W'(mag16) : MAG_W'(i_raw[15:0]);
                if (i_raw[15:0] == 16'h8000) n_sp = SP_NEG;
            end
            FMT_I32: begin
                n_neg = i_raw[31];
                n_sh  = 8'd31;
                n_mag = i_raw[31] ? mag32[MAG_W-1:0] : i_raw[MAG_W-1:0];
                if (i_raw == 32'h8000_0000) n_sp = SP_NEG;
            end
            FMT_I24: begin
                n_neg = i_raw[31];
                n_sh  = 8'd23;
                n_mag = i_raw[31] ? MAG_W'(mag24) : MAG_W'(i_raw[31:8]);
                if (i_raw[31:8] == 24'h80_0000) n_sp = SP_NEG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= n_neg;
        r_mag  <= n_mag;
        r_sh1  <= n_sh;
        r_sp1  <= n_sp;
        // stage 2
        r_prod <= PROD_W'(r_mag) * PROD_W'(SCALE);
        r_neg2 <= r_neg1;
        r_sh2  <= r_sh1;
        r_sp2  <= r_sp1;
        // stage 3
        r_sample <= n_sample;
    end

    // stage 3: round half to even at bit r_sh2, clamp to 32767
    always_comb begin
        q         = r_prod >> r_sh2;
        guard_vec = r_prod >> (r_sh2 - 8'd1);
        guard     = guard_vec[0];
        low_mask  = (PROD_W'(1) << (r_sh2 - 8'd1)) - PROD_W'(1);
        sticky    = |(r_prod & low_mask);
        round_up  = guard & (sticky | q[0]);
        q_rnd     = q + PROD_W'(round_up);
        q_sat     = (q_rnd > PROD_W'(SCALE)) ? SCALE : q_rnd[QMAG_W-1:0];
        unique case (r_sp2)
            SP_NONE: n_sample = r_neg2 ? -t_pcm'({1'b0, q_sat}) : t_pcm'({1'b0, q_sat});
            SP_ZERO: n_sample = '0;
            SP_POS:  n_sample = t_pcm'({1'b0, SCALE});
            SP_NEG:  n_sample = t_pcm'({1'b1, {QMAG_W{1'b0}}});
        endcase
    end

    assign o_sample = r_sample;

endmodule

// File: rtl/core/afrc_datapath.sv
// afrc_datapath: configuration registers, input capture, two decode lanes,
// rate accumulator, chunk counter and output register.
// Depends on afrc_pkg, afrc_if and afrc_dec_lane.
module afrc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [afrc_pkg::RAW_W-1:0]  i_raw_left,
    input  logic [afrc_pkg::RAW_W-1:0]  i_raw_right,
    input  logic                        i_silent,
    input  afrc_pkg::t_dp_cmd           i_cmd,
    output afrc_pkg::t_dp_status        o_status,
    afrc_cfg_if.sink                    i_cfg,
    afrc_out_if.source                  o_out
);
    import afrc_pkg::*;

    logic [FMT_W-1:0]   r_fmt;
    logic               r_in_stereo, r_out_stereo;
    logic [RATE_W-1:0]  r_irate, r_orate;
    logic [CHUNK_W-1:0] r_chunk;

    logic [RAW_W-1:0]   r_raw_l, r_raw_r;
    logic               r_silent;

    logic [ACC_W-1:0]   r_accum, n_accum;
    logic [CHUNK_W-1:0] r_fill, n_fill;

    t_pcm               r_pcm_l, r_pcm_r;
    logic               r_end;
    logic               r_out_valid;

    t_pcm               dec_l, dec_r, smp_l, smp_r;
    logic [RATE_W-1:0]  irate, orate;
    logic [CHUNK_W-1:0] chunk;
    logic [ACC_W:0]     acc_sum;
    logic [CHUNK_W-1:0] fill_inc;
    logic               frame_end;
    logic               cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FMT_RESET;
            r_in_stereo  <= 1'b1;
            r_out_stereo <= 1'b1;
            r_irate      <= RATE_RESET;
            r_orate      <= RATE_RESET;
            r_chunk      <= CHUNK_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_SAMPLE_FORMAT: r_fmt        <= i_cfg.data[FMT_W-1:0];
                REG_INPUT_STEREO:  r_in_stereo  <= i_cfg.data[0];
                REG_OUTPUT_STEREO: r_out_stereo <= i_cfg.data[0];
                REG_INPUT_RATE:    r_irate      <= i_cfg.data[RATE_W-1:0];
                REG_OUTPUT_RATE:   r_orate      <= i_cfg.data[RATE_W-1:0];
                REG_CHUNK_FRAMES:  r_chunk      <= i_cfg.data[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_raw_l  <= i_raw_left;
            r_raw_r  <= i_raw_right;
            r_silent <= i_silent;
        end
    end

    afrc_dec_lane u_lane_l (
        .i_clk    (i_clk),
        .i_raw    (r_raw_l),
        .i_fmt    (r_fmt),
        .o_sample (dec_l)
    );

    afrc_dec_lane u_lane_r (
        .i_clk    (i_clk),
        .i_raw    (r_raw_r),
        .i_fmt    (r_fmt),
        .o_sample (dec_r)
    );

    assign smp_l = r_silent ? '0 : dec_l;
    assign smp_r = (r_silent || !r_out_stereo) ? '0 : (r_in_stereo ? dec_r : dec_l);

    // effective rates and chunk size
    assign irate = (r_irate == '0) ? RATE_W'(1) : r_irate;
    assign orate = (r_orate == '0) ? ORATE_ZERO_SUB : r_orate;
    assign chunk = (r_chunk == '0) ? CHUNK_W'(1) : r_chunk;

    assign acc_sum   = {1'b0, r_accum} + (ACC_W + 1)'(orate);
    assign fill_inc  = r_fill + CHUNK_W'(1);
    assign frame_end = (fill_inc >= chunk) || (fill_inc == '0);

    always_comb begin
        n_accum = r_accum;
        n_fill  = r_fill;
        if (i_cmd.acc_add && (irate != orate)) begin
            n_accum = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        end
        if (i_cmd.emit) begin
            if (irate != orate) n_accum = r_accum - ACC_W'(irate);
            n_fill = frame_end ? '0 : fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_accum <= n_accum;
            r_fill  <= n_fill;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pcm_l <= smp_l;
            r_pcm_r <= smp_r;
            r_end   <= frame_end;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pcm_left  = r_pcm_l;
    assign o_out.pcm_right = r_pcm_r;
    assign o_out.chunk_end = r_end;

    assign o_status.rate_eq  = (irate == orate);
    assign o_status.rate_ge  = (r_accum >= ACC_W'(irate));
    assign o_status.out_free = !r_out_valid || o_out.ready;

endmodule

// File: rtl/core/afrc_ctrl.sv
// afrc_ctrl: sequencer for one input frame: capture, wait for the decode
// lanes, step the rate accumulator, emit frames. Depends on afrc_pkg.
module afrc_ctrl #(
    parameter int MAX_REPEAT = afrc_pkg::MAX_REPEAT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  afrc_pkg::t_dp_status  i_status,
    output afrc_pkg::t_dp_cmd     o_cmd
);
    import afrc_pkg::*;

    localparam int CNT_W = $clog2(MAX_REPEAT + 1);
    localparam logic [1:0] DEC_WAIT = 2'd2; // wait count in S_DEC while the decode lanes fill

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_wait, n_wait;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             more;

    // equal rates give exactly one frame; otherwise drain while accum >= rate, up to MAX_REPEAT frames
    assign more = i_status.rate_eq ? (r_cnt == '0)
                                   : ((r_cnt < CNT_W'(MAX_REPEAT)) && i_status.rate_ge);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_wait    = DEC_WAIT;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (r_wait == '0) n_state = S_ACC;
                else n_wait = r_wait - 2'd1;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_cnt         = '0;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!more) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/core/afrc_checker.sv
// afrc_checker: port-level assertions for audio_format_rate_chunker and the
// bind that attaches them. Depends on afrc_pkg.
module afrc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input afrc_pkg::t_pcm i_pcm_left,
    input afrc_pkg::t_pcm i_pcm_right,
    input logic           i_chunk_end
);
    import afrc_pkg::*;

    // one word at a time: input closes right after an accept
    a_in_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted in back-to-back cycles");

    // no output word can appear in the cycle after an input accept
    a_no_early_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("output word before decode finished");

    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pcm_left) && $stable(i_pcm_right) && $stable(i_chunk_end))
        else $error("stalled output word changed");

endmodule

bind audio_format_rate_chunker afrc_checker u_afrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pcm_left  (o_out.pcm_left),
    .i_pcm_right (o_out.pcm_right),
    .i_chunk_end (o_out.chunk_end)
);

// File: dv/afrc_pcm_checker.sv
// afrc_pcm_checker: watches the input, output and config channels of the
// audio format/rate chunker, predicts each output word and compares it.
// Depends on afrc_pkg and afrc_if.
module afrc_pcm_checker #(
    parameter int MAX_REPEAT = afrc_pkg::MAX_REPEAT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    afrc_in_if   in_ch,
    afrc_out_if  out_ch,
    afrc_cfg_if  cfg_ch,
    output int   o_err_count,
    output int   o_pending
);
    import afrc_pkg::*;

    localparam logic [ACC_W-1:0] ACC_LIMIT = {ACC_W{1'b1}};
    localparam t_pcm PCM_MAX = 16'sh7FFF;
    localparam t_pcm PCM_MIN = 16'sh8000;

    typedef struct packed {
        t_pcm left;
        t_pcm right;
        logic last;
    } t_pcm_frame;

    t_pcm_frame due_frames[$];

    logic [FMT_W-1:0]   fmt_r;
    logic               in_stereo_r;
    logic               out_stereo_r;
    logic [RATE_W-1:0]  irate_r;
    logic [RATE_W-1:0]  orate_r;
    logic [CHUNK_W-1:0] chunk_r;
    logic [ACC_W-1:0]   acc_r;
    logic [CHUNK_W-1:0] fill_r;

    // mant / 2^sh times 32767, round half to even, clamp to 32767
    function automatic t_pcm scale_to_pcm(input logic neg, input logic [63:0] mant,
                                          input int unsigned sh);
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        t_pcm        mag;
        if (sh >= 64) return '0;
        prod = mant * 64'd32767;
        q    = prod >> sh;
        rem  = prod & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        if (q > 64'd32767) q = 64'd32767;
        mag = q[PCM_W-1:0];
        return neg ? -mag : mag;
    endfunction

    function automatic t_pcm decode_float(input logic [31:0] b);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] frac;
        neg  = b[31];
        ex   = b[30:23];
        frac = b[22:0];
        if (ex == 8'hFF && frac != '0) return '0;   // NaN
        if (ex >= 8'd127) return neg ? PCM_MIN : PCM_MAX;
        if (ex == 8'd0) return scale_to_pcm(neg, {41'd0, frac}, 149);
        return scale_to_pcm(neg, {40'd0, 1'b1, frac}, 150 - int'(ex));
    endfunction

    // two's complement in bits+1 bits, value s / 2^bits
    function automatic t_pcm decode_int(input logic [31:0] raw, input int unsigned bits);
        logic [31:0] signbit;
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] mag;
        signbit = 32'd1 << bits;
        mask    = (signbit << 1) - 32'd1;
        v       = raw & mask;
        if ((v & signbit) != '0) begin
            mag = (~v + 32'd1) & mask;
            if (mag == signbit) return PCM_MIN;
            if (mag == '0) return '0;
            return scale_to_pcm(1'b1, {32'd0, mag}, bits);
        end
        return scale_to_pcm(1'b0, {32'd0, v}, bits);
    endfunction

    function automatic t_pcm decode_word(input logic [31:0] raw);
        case (fmt_r)
            FMT_F32: return decode_float(raw);
            FMT_I16: return decode_int({16'd0, raw[15:0]}, 15);
            FMT_I32: return decode_int(raw, 31);
            default: return decode_int({8'd0, raw[31:8]}, 23);
        endcase
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SAMPLE_FORMAT: fmt_r        = val[FMT_W-1:0];
            REG_INPUT_STEREO:  in_stereo_r  = val[0];
            REG_OUTPUT_STEREO: out_stereo_r = val[0];
            REG_INPUT_RATE:    irate_r      = val[RATE_W-1:0];
            REG_OUTPUT_RATE:   orate_r      = val[RATE_W-1:0];
            REG_CHUNK_FRAMES:  chunk_r      = val[CHUNK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_frames(input logic [31:0] raw_l, input logic [31:0] raw_r,
                                           input logic silent);
        t_pcm               left;
        t_pcm               right;
        logic [RATE_W-1:0]  irate;
        logic [RATE_W-1:0]  orate;
        logic [CHUNK_W-1:0] chunk;
        logic [ACC_W:0]     sum;
        int                 n_due;
        t_pcm_frame         fr;
        left  = '0;
        right = '0;
        if (!silent) begin
            left  = decode_word(raw_l);
            right = in_stereo_r ? decode_word(raw_r) : left;
        end
        irate = (irate_r == '0) ? RATE_W'(1) : irate_r;
        orate = (orate_r == '0) ? ORATE_ZERO_SUB : orate_r;
        chunk = (chunk_r == '0) ? CHUNK_W'(1) : chunk_r;
        if (irate == orate) begin
            n_due = 1;
        end else begin
            sum   = acc_r + orate;
            acc_r = (sum > ACC_LIMIT) ? ACC_LIMIT : sum[ACC_W-1:0];
            n_due = 0;
            while (n_due < MAX_REPEAT && acc_r >= irate) begin
                acc_r = acc_r - irate;
                n_due++;
            end
        end
        for (int k = 0; k < n_due; k++) begin
            fill_r  = fill_r + 1'b1;
            fr.last = (fill_r >= chunk || fill_r == '0);
            if (fr.last) fill_r = '0;
            fr.left  = left;
            fr.right = out_stereo_r ? right : '0;
            due_frames.insert(due_frames.size(), fr);
        end
    endfunction

    function automatic void check_frame();
        t_pcm_frame exp_fr;
        if (due_frames.size() == 0) begin
            o_err_count++;
            $display("%0t: output word with none expected: left %0d right %0d end %0b",
                     $time, out_ch.pcm_left, out_ch.pcm_right, out_ch.chunk_end);
            return;
        end
        exp_fr = due_frames.pop_front();
        if (out_ch.pcm_left !== exp_fr.left) begin
            o_err_count++;
            $display("%0t: pcm_left expected %0d, actual %0d",
                     $time, exp_fr.left, out_ch.pcm_left);
        end
        if (out_ch.pcm_right !== exp_fr.right) begin
            o_err_count++;
            $display("%0t: pcm_right expected %0d, actual %0d",
                     $time, exp_fr.right, out_ch.pcm_right);
        end
        if (out_ch.chunk_end !== exp_fr.last) begin
            o_err_count++;
            $display("%0t: chunk_end expected %0b, actual %0b",
                     $time, exp_fr.last, out_ch.chunk_end);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_r        = FMT_RESET;
            in_stereo_r  = 1'b1;
            out_stereo_r = 1'b1;
            irate_r      = RATE_RESET;
            orate_r      = RATE_RESET;
            chunk_r      = CHUNK_RESET;
            acc_r        = '0;
            fill_r       = '0;
            o_err_count  = 0;
            due_frames.delete();
        end else begin
            // output words at this edge always stem from earlier input words
            if (out_ch.valid && out_ch.ready) check_frame();
            if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                predict_frames(in_ch.raw_left, in_ch.raw_right, in_ch.silent);
        end
        o_pending = due_frames.size();
    end

endmodule

// File: dv/tb_top.sv
// tb_top: stimulus and verdict for audio_format_rate_chunker; directed format
// corners, then random words over a sweep of rate and chunk settings.
// Depends on afrc_pkg, afrc_if, the RTL and afrc_pcm_checker.
module tb_top;
    import afrc_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int N_PHASES        = 13;
    localparam int ITEMS_PER_PHASE = 29;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int MAX_GAP         = 17;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_VOID_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOID_B = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   frames_pending;
    int   cycles    = 0;
    int   sink_wait = 0;
    logic sink_hold = 1'b0;
    logic idle_en   = 1'b1;

    afrc_in_if  in_if ();
    afrc_out_if out_if ();
    afrc_cfg_if cfg_if ();

    audio_format_rate_chunker #(
        .MAX_REPEAT(MAX_REPEAT_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    afrc_pcm_checker #(
        .MAX_REPEAT(MAX_REPEAT_DEF)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_if),
        .out_ch      (out_if),
        .cfg_ch      (cfg_if),
        .o_err_count (err_count),
        .o_pending   (frames_pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sink: after each word taken, stall a random number of cycles while idle_en is set
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready)
            sink_wait = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else if (sink_hold) begin
            out_if.ready = 1'b0;
        end else if (sink_wait > 0) begin
            out_if.ready = 1'b0;
            sink_wait--;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    task automatic hold_output(input int n);
        @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (n) @(posedge i_clk);
        sink_hold = 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] raw_l, input logic [31:0] raw_r,
                              input logic silent);
        int gap;
        gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid     = 1'b1;
        in_if.raw_left  = raw_l;
        in_if.raw_right = raw_r;
        in_if.silent    = silent;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (frames_pending != 0) @(negedge i_clk);
        // a word that causes no output may still be in the pipeline
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // unused upper data bits are filled with noise, the block must mask them
    task automatic configure(input logic [FMT_W-1:0] fmt, input logic in_st,
                             input logic out_st, input logic [RATE_W-1:0] irate,
                             input logic [RATE_W-1:0] orate,
                             input logic [CHUNK_W-1:0] chunk);
        write_reg(REG_SAMPLE_FORMAT, {17'($urandom), fmt});
        write_reg(REG_INPUT_STEREO, {18'($urandom), in_st});
        write_reg(REG_OUTPUT_STEREO, {18'($urandom), out_st});
        write_reg(REG_INPUT_RATE, irate);
        write_reg(REG_OUTPUT_RATE, orate);
        write_reg(REG_CHUNK_FRAMES, {3'($urandom), chunk});
        write_reg(REG_VOID_A, 19'($urandom));
        write_reg(REG_VOID_B, 19'($urandom));
    endtask

    function automatic logic [31:0] pick_raw(input logic [FMT_W-1:0] fmt);
        logic [31:0] w;
        logic        s;
        int          pick;
        w    = $urandom;
        s    = w[0];
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            // full scale for ints, inf/NaN for float
            case (fmt)
                FMT_I16: w[15:0] = {s, {15{~s}}};
                FMT_I24: w[31:8] = {s, {23{~s}}};
                FMT_I32: w       = {s, {31{~s}}};
                default: w[30:23] = 8'hFF;
            endcase
        end else if (fmt == FMT_F32 && pick == 1) begin
            w[30:23] = 8'd0;
        end else if (fmt == FMT_F32 && pick <= 5) begin
            w[30:23] = 8'($urandom_range(100, 127));
        end
        return w;
    endfunction

    task automatic send_batch(input int n, input logic [FMT_W-1:0] fmt);
        for (int i = 0; i < n; i++)
            send_frame(pick_raw(fmt), pick_raw(fmt), $urandom_range(0, 9) == 0);
        stop_input();
    endtask

    initial begin
        logic [FMT_W-1:0]   fmt;
        logic [RATE_W-1:0]  irate;
        logic [RATE_W-1:0]  orate;
        logic [CHUNK_W-1:0] chunk;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.raw_left  = '0;
        in_if.raw_right = '0;
        in_if.silent    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // float corners at the reset settings
        send_frame(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_frame(32'h3F80_0000, 32'hBF80_0000, 1'b0);
        send_frame(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        send_frame(32'h7FC0_0000, 32'hFFFF_FFFF, 1'b0);
        send_frame(32'h3F00_0000, 32'hBF00_0000, 1'b0);  // exact ties
        send_frame(32'h3F7F_FFFF, 32'hBF7F_FFFF, 1'b0);
        send_frame(32'h3780_0000, 32'h3800_0000, 1'b0);  // around half a step
        send_frame(32'h0000_0001, 32'h8080_0000, 1'b0);
        send_frame(32'h3F80_0000, 32'h3F80_0000, 1'b1);
        stop_input();
        wait_idle();

        configure(FMT_I16, 1'b1, 1'b1, RATE_RESET, RATE_RESET, 16'd3);
        send_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b0);
        send_frame(32'h1234_4000, 32'h0000_C000, 1'b0);
        send_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        stop_input();
        wait_idle();

        configure(FMT_I32, 1'b1, 1'b1, RATE_RESET, RATE_RESET, 16'd3);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_frame(32'h4000_0000, 32'hC000_0000, 1'b0);
        send_frame(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        stop_input();
        wait_idle();

        configure(FMT_I24, 1'b1, 1'b1, RATE_RESET, RATE_RESET, 16'd3);
        send_frame(32'h7FFF_FFFF, 32'h8000_00FF, 1'b0);
        send_frame(32'h4000_0000, 32'hC000_00AB, 1'b0);
        send_frame(32'h0000_01FF, 32'hFFFF_FF00, 1'b0);
        stop_input();
        wait_idle();

        configure(FMT_I24, 1'b0, 1'b0, RATE_RESET, RATE_RESET, 16'd2);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        stop_input();
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            chunk = 16'($urandom_range(2, 40));
            case (ph)
                0:  begin irate = 19'd48000;  orate = 19'd48000;  chunk = 16'd7;     end
                1:  begin irate = 19'd8000;   orate = 19'd48000;  chunk = 16'hFFFF;  end
                // chunk drops below the fill reached in the previous phase
                2:  begin irate = 19'd8000;   orate = 19'd48000;  chunk = 16'd5;     end
                3:  begin irate = 19'd48000;  orate = 19'd8000;   chunk = 16'd3;     end
                4:  begin irate = 19'd1;      orate = 19'd384000; chunk = 16'd1;     end
                5:  begin irate = 19'd0;      orate = 19'd0;      chunk = 16'd0;     end
                6:  begin irate = 19'd44100;  orate = 19'd48000;                     end
                7:  begin irate = 19'd384000; orate = 19'd1;      chunk = 16'd2;     end
                8:  begin irate = 19'd0;      orate = 19'd1;                         end
                9:  begin irate = 19'd3;      orate = 19'd47;                        end
                10: begin irate = 19'd48000;  orate = 19'd44100;  chunk = 16'hFFFF;  end
                11: begin irate = 19'h7FFFF;  orate = 19'h7FFFF;  chunk = 16'd960;   end
                default: begin irate = 19'd1; orate = 19'h7FFFF;  chunk = 16'd0;     end
            endcase
            fmt     = ph[FMT_W-1:0];
            idle_en = (ph % 4 != 1);
            configure(fmt, ph % 3 != 1, ph % 5 != 4, irate, orate, chunk);
            if (ph == 2) begin
                fork
                    hold_output(HOLD_CYCLES);
                    send_batch(ITEMS_PER_PHASE, fmt);
                join
            end else begin
                send_batch(ITEMS_PER_PHASE, fmt);
            end
            wait_idle();
        end

        if (err_count == 0 && frames_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
